FILE: hdl/ofme_pkg.sv
// ----------------------------------------------------------------------------
// ofme_pkg
// shared types, constants and helpers of the optical flow motion estimator
// ----------------------------------------------------------------------------
`default_nettype none

package ofme_pkg;

    localparam int unsigned CORDIC_STEPS = 20;
    localparam int unsigned STEP_W       = 5;
    localparam int signed   ANGLE_LIMIT  = 8900;
    localparam logic signed [63:0] CPI_Q32  = 64'sd915663668;
    localparam logic signed [63:0] MS_PER_S = 64'sd1000;

    localparam logic [16:0] POS_GAIN_RST  = 17'd16384;
    localparam logic [16:0] TILT_GAIN_RST = 17'd16384;
    localparam logic [23:0] OFFS_GAIN_RST = 24'd65536;
    localparam logic [16:0] VEL_GAIN_RST  = 17'd6554;

    // register indexes
    localparam logic [2:0] REG_POS_GAIN  = 3'd0;
    localparam logic [2:0] REG_TILT_GAIN = 3'd1;
    localparam logic [2:0] REG_OFFS_GAIN = 3'd2;
    localparam logic [2:0] REG_VEL_GAIN  = 3'd3;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    // arctangent of 2^-i in centidegree/65536
    function automatic logic signed [33:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:    v = 34'sd294912000;
            5'd1:    v = 34'sd174096719;
            5'd2:    v = 34'sd91987925;
            5'd3:    v = 34'sd46694507;
            5'd4:    v = 34'sd23437865;
            5'd5:    v = 34'sd11730359;
            5'd6:    v = 34'sd5866610;
            5'd7:    v = 34'sd2933484;
            5'd8:    v = 34'sd1466765;
            5'd9:    v = 34'sd733385;
            5'd10:   v = 34'sd366693;
            5'd11:   v = 34'sd183346;
            5'd12:   v = 34'sd91673;
            5'd13:   v = 34'sd45837;
            5'd14:   v = 34'sd22918;
            5'd15:   v = 34'sd11459;
            5'd16:   v = 34'sd5730;
            5'd17:   v = 34'sd2865;
            5'd18:   v = 34'sd1432;
            5'd19:   v = 34'sd716;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ofme_muldiv.sv
// ----------------------------------------------------------------------------
// ofme_muldiv
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ofme_muldiv (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ofme_pkg::md_req_t    req,
    input  wire  signed [63:0]   a,
    input  wire  signed [63:0]   b,
    output logic                 done,
    output logic signed [63:0]   res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t      state_reg;
    logic [63:0] acc_reg;
    logic [63:0] ma_reg;
    logic [63:0] mb_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;

    logic [63:0] r2;
    logic        fits;
    logic [63:0] qn;

    always_comb
    begin
        r2   = {mb_reg[62:0], ma_reg[63]};
        fits = (r2 >= $unsigned(b));
        qn   = {acc_reg[62:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done      <= 1'b0;
            acc_reg   <= '0;
            ma_reg    <= '0;
            mb_reg    <= '0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            res       <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        ma_reg  <= a[63] ? $unsigned(-a) : $unsigned(a);
                        if (req.op == ofme_pkg::MD_MUL)
                        begin
                            mb_reg    <= b[63] ? $unsigned(-b) : $unsigned(b);
                            neg_reg   <= a[63] ^ b[63];
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            // mb holds the partial remainder during division
                            mb_reg    <= '0;
                            neg_reg   <= a[63];
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mb_reg == '0)
                    begin
                        res       <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
                        done      <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        if (mb_reg[0])
                            acc_reg <= acc_reg + ma_reg;
                        ma_reg <= {ma_reg[62:0], 1'b0};
                        mb_reg <= {1'b0, mb_reg[63:1]};
                    end
                end
                ST_DIV:
                begin
                    // divisor stays on b while the sequencer holds the state
                    mb_reg  <= fits ? r2 - $unsigned(b) : r2;
                    ma_reg  <= {ma_reg[62:0], 1'b0};
                    acc_reg <= qn;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        res       <= neg_reg ? -$signed(qn) : $signed(qn);
                        done      <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ofme_cordic.sv
// ----------------------------------------------------------------------------
// ofme_cordic
// iterative rotation cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ofme_cordic (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  signed [14:0]  angle,
    output logic                done,
    output logic signed [33:0]  x,
    output logic signed [33:0]  y
);

    logic                            busy_reg;
    logic [ofme_pkg::STEP_W-1:0]     step_reg;
    logic signed [33:0]              z_reg;
    logic signed [14:0]              ang;
    logic signed [33:0]              dx;
    logic signed [33:0]              dy;
    logic signed [33:0]              at;

    always_comb
    begin
        if (angle > 15'sd8900)
            ang = 15'sd8900;
        else if (angle < -15'sd8900)
            ang = -15'sd8900;
        else
            ang = angle;
        dx = y >>> step_reg;
        dy = x >>> step_reg;
        at = ofme_pkg::atan_entry(step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
            z_reg    <= '0;
            x        <= '0;
            y        <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                    x        <= 34'sd1073741824;
                    y        <= '0;
                    z_reg    <= 34'(ang) <<< 16;
                end
            end
            else
            begin
                if (!z_reg[33])
                begin
                    x     <= x - dx;
                    y     <= y + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x     <= x + dx;
                    y     <= y - dy;
                    z_reg <= z_reg + at;
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == ofme_pkg::STEP_W'(ofme_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/optical_flow_motion_estimator.sv
// ----------------------------------------------------------------------------
// optical_flow_motion_estimator
// flow sample filtering, tilt compensation, velocity and altitude scaling
// ----------------------------------------------------------------------------
// latency per item is set by the shared one-bit-per-cycle
// multiply/divide unit (up to four divisions) and the 20-step cordic
// one item at a time: a new item is taken after the result has been taken
// reset restores default gains and clears all filter, velocity and history state
`default_nettype none

module optical_flow_motion_estimator (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [2:0]   cfg_addr,
    input  wire  [23:0]  cfg_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // sample_time_ms, raw_dx, raw_dy, roll_cdeg, pitch_cdeg, altitude, zero fill
    input  wire  [127:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // position_x, position_y, velocity_x, velocity_y
    output logic [127:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POS_ISSUE, ST_POS_WAIT,
        ST_TAN_ISSUE, ST_TAN_CWAIT, ST_TAN_DISSUE, ST_TAN_DWAIT,
        ST_TAN_GISSUE, ST_TAN_GWAIT, ST_TAN_FISSUE, ST_TAN_FWAIT,
        ST_COMP,
        ST_VEL_RISSUE, ST_VEL_RWAIT, ST_VEL_DISSUE, ST_VEL_DWAIT,
        ST_VEL_FISSUE, ST_VEL_FWAIT,
        ST_CPI_ISSUE, ST_CPI_WAIT,
        ST_SC_ISSUE, ST_SC_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [16:0] pos_gain_reg;
    logic [16:0] tilt_gain_reg;
    logic [23:0] offs_gain_reg;
    logic [16:0] vel_gain_reg;

    logic signed [31:0] filt_reg   [2];
    logic signed [31:0] bias_reg   [2];
    logic signed [31:0] prev_o_reg [2];
    logic signed [31:0] vel_reg    [2];
    logic signed [31:0] o_reg      [2];
    logic signed [31:0] res_reg    [4];
    logic [31:0]        prev_time_reg;
    logic               have_prev_reg;

    logic [31:0]        t_reg;
    logic signed [15:0] raw_reg [2];
    logic signed [14:0] ang_reg [2];
    logic signed [31:0] alt_reg;
    logic [31:0]        dt_reg;
    logic               axis_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] tmp_reg;
    logic signed [63:0] cpi_reg;

    ofme_pkg::md_req_t  md_req;
    logic signed [63:0] md_a;
    logic signed [63:0] md_b;
    logic               md_done;
    logic signed [63:0] md_res;

    logic               cd_start;
    logic               cd_done;
    logic signed [33:0] cd_x;
    logic signed [33:0] cd_y;
    logic signed [33:0] x_clamp;
    logic signed [31:0] sc_val;
    logic [31:0]        dt_now;

    ofme_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (md_a),
        .b     (md_b),
        .done  (md_done),
        .res   (md_res)
    );

    ofme_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .angle (ang_reg[axis_reg]),
        .done  (cd_done),
        .x     (cd_x),
        .y     (cd_y)
    );

    always_comb
    begin
        x_clamp = (cd_x < 34'sd1) ? 34'sd1 : cd_x;
        dt_now  = t_reg - prev_time_reg;
        case (k_reg)
            2'd0:    sc_val = o_reg[0];
            2'd1:    sc_val = o_reg[1];
            2'd2:    sc_val = vel_reg[0];
            default: sc_val = vel_reg[1];
        endcase

        md_req.start = 1'b0;
        md_req.op    = ofme_pkg::MD_MUL;
        md_a         = '0;
        md_b         = '0;
        cd_start     = 1'b0;
        case (state_reg)
            ST_POS_ISSUE:
            begin
                md_req.start = 1'b1;
                md_a = (64'(raw_reg[axis_reg]) <<< 16) - 64'(filt_reg[axis_reg]);
                md_b = $signed({47'd0, pos_gain_reg});
            end
            ST_TAN_ISSUE: cd_start = 1'b1;
            ST_TAN_DISSUE, ST_TAN_DWAIT:
            begin
                md_req.start = (state_reg == ST_TAN_DISSUE);
                md_req.op    = ofme_pkg::MD_DIV;
                md_a = 64'(cd_y) <<< 16;
                md_b = 64'(x_clamp);
            end
            ST_TAN_GISSUE:
            begin
                md_req.start = 1'b1;
                md_a = tmp_reg;
                md_b = $signed({40'd0, offs_gain_reg});
            end
            ST_TAN_FISSUE:
            begin
                md_req.start = 1'b1;
                md_a = tmp_reg - 64'(bias_reg[axis_reg]);
                md_b = $signed({47'd0, tilt_gain_reg});
            end
            ST_VEL_RISSUE:
            begin
                md_req.start = 1'b1;
                md_a = 64'(o_reg[axis_reg]) - 64'(prev_o_reg[axis_reg]);
                md_b = ofme_pkg::MS_PER_S;
            end
            ST_VEL_DISSUE, ST_VEL_DWAIT:
            begin
                md_req.start = (state_reg == ST_VEL_DISSUE);
                md_req.op    = ofme_pkg::MD_DIV;
                md_a = tmp_reg;
                md_b = $signed({32'd0, dt_reg});
            end
            ST_VEL_FISSUE:
            begin
                md_req.start = 1'b1;
                md_a = tmp_reg - 64'(vel_reg[axis_reg]);
                md_b = $signed({47'd0, vel_gain_reg});
            end
            ST_CPI_ISSUE:
            begin
                md_req.start = 1'b1;
                md_a = 64'(alt_reg);
                md_b = ofme_pkg::CPI_Q32;
            end
            ST_SC_ISSUE:
            begin
                md_req.start = 1'b1;
                md_a = 64'(sc_val);
                md_b = cpi_reg;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_gain_reg  <= ofme_pkg::POS_GAIN_RST;
            tilt_gain_reg <= ofme_pkg::TILT_GAIN_RST;
            offs_gain_reg <= ofme_pkg::OFFS_GAIN_RST;
            vel_gain_reg  <= ofme_pkg::VEL_GAIN_RST;
            for (int i = 0; i < 2; i++)
            begin
                filt_reg[i]   <= '0;
                bias_reg[i]   <= '0;
                prev_o_reg[i] <= '0;
                vel_reg[i]    <= '0;
            end
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    ofme_pkg::REG_POS_GAIN:  pos_gain_reg  <= cfg_data[16:0];
                    ofme_pkg::REG_TILT_GAIN: tilt_gain_reg <= cfg_data[16:0];
                    ofme_pkg::REG_OFFS_GAIN: offs_gain_reg <= cfg_data;
                    ofme_pkg::REG_VEL_GAIN:  vel_gain_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        t_reg      <= s_tdata[31:0];
                        raw_reg[0] <= s_tdata[47:32];
                        raw_reg[1] <= s_tdata[63:48];
                        ang_reg[0] <= s_tdata[78:64];
                        ang_reg[1] <= s_tdata[93:79];
                        alt_reg    <= s_tdata[125:94];
                        axis_reg   <= 1'b0;
                        state_reg  <= ST_POS_ISSUE;
                    end
                end
                ST_POS_ISSUE: state_reg <= ST_POS_WAIT;
                ST_POS_WAIT:
                begin
                    if (md_done)
                    begin
                        filt_reg[axis_reg] <= ofme_pkg::sat32(
                            64'(filt_reg[axis_reg]) + (md_res >>> 16));
                        axis_reg  <= ~axis_reg;
                        state_reg <= axis_reg ? ST_TAN_ISSUE : ST_POS_ISSUE;
                    end
                end
                ST_TAN_ISSUE: state_reg <= ST_TAN_CWAIT;
                ST_TAN_CWAIT:
                begin
                    if (cd_done)
                        state_reg <= ST_TAN_DISSUE;
                end
                ST_TAN_DISSUE: state_reg <= ST_TAN_DWAIT;
                ST_TAN_DWAIT:
                begin
                    if (md_done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= ST_TAN_GISSUE;
                    end
                end
                ST_TAN_GISSUE: state_reg <= ST_TAN_GWAIT;
                ST_TAN_GWAIT:
                begin
                    if (md_done)
                    begin
                        tmp_reg   <= md_res >>> 16;
                        state_reg <= ST_TAN_FISSUE;
                    end
                end
                ST_TAN_FISSUE: state_reg <= ST_TAN_FWAIT;
                ST_TAN_FWAIT:
                begin
                    if (md_done)
                    begin
                        bias_reg[axis_reg] <= ofme_pkg::sat32(
                            64'(bias_reg[axis_reg]) + (md_res >>> 16));
                        axis_reg  <= ~axis_reg;
                        state_reg <= axis_reg ? ST_COMP : ST_TAN_ISSUE;
                    end
                end
                ST_COMP:
                begin
                    for (int i = 0; i < 2; i++)
                        o_reg[i] <= ofme_pkg::sat32(64'(filt_reg[i]) - 64'(bias_reg[i]));
                    dt_reg        <= dt_now;
                    prev_time_reg <= t_reg;
                    have_prev_reg <= 1'b1;
                    axis_reg      <= 1'b0;
                    // first sample or repeated timestamp keeps velocity
                    state_reg     <= (have_prev_reg && dt_now != '0) ? ST_VEL_RISSUE
                                                                     : ST_CPI_ISSUE;
                end
                ST_VEL_RISSUE: state_reg <= ST_VEL_RWAIT;
                ST_VEL_RWAIT:
                begin
                    if (md_done)
                    begin
                        tmp_reg   <= md_res;
                        state_reg <= ST_VEL_DISSUE;
                    end
                end
                ST_VEL_DISSUE: state_reg <= ST_VEL_DWAIT;
                ST_VEL_DWAIT:
                begin
                    if (md_done)
                    begin
                        tmp_reg   <= 64'(ofme_pkg::sat32(md_res));
                        state_reg <= ST_VEL_FISSUE;
                    end
                end
                ST_VEL_FISSUE: state_reg <= ST_VEL_FWAIT;
                ST_VEL_FWAIT:
                begin
                    if (md_done)
                    begin
                        vel_reg[axis_reg] <= ofme_pkg::sat32(
                            64'(vel_reg[axis_reg]) + (md_res >>> 16));
                        axis_reg  <= ~axis_reg;
                        state_reg <= axis_reg ? ST_CPI_ISSUE : ST_VEL_RISSUE;
                    end
                end
                ST_CPI_ISSUE:
                begin
                    prev_o_reg[0] <= o_reg[0];
                    prev_o_reg[1] <= o_reg[1];
                    state_reg     <= ST_CPI_WAIT;
                end
                ST_CPI_WAIT:
                begin
                    if (md_done)
                    begin
                        cpi_reg   <= md_res >>> 32;
                        k_reg     <= '0;
                        state_reg <= ST_SC_ISSUE;
                    end
                end
                ST_SC_ISSUE: state_reg <= ST_SC_WAIT;
                ST_SC_WAIT:
                begin
                    if (md_done)
                    begin
                        res_reg[k_reg] <= ofme_pkg::sat32(md_res >>> 16);
                        k_reg          <= k_reg + 2'd1;
                        state_reg      <= (k_reg == 2'd3) ? ST_OUT : ST_SC_ISSUE;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_optical_flow_motion_estimator.sv
// ----------------------------------------------------------------------------
// tb_optical_flow_motion_estimator
// streams flow samples through the estimator under several gain settings and
// idle patterns, and checks every result against a bit-exact predictor
// ----------------------------------------------------------------------------
`default_nettype none

class flow_scoreboard;
    logic [127:0] pending[$];
    int           errors;

    logic [16:0] pos_gain;
    logic [16:0] tilt_gain;
    logic [23:0] offs_gain;
    logic [16:0] vel_gain;

    logic signed [31:0] filt_x, filt_y, bias_x, bias_y, prev_x, prev_y, vel_x, vel_y;
    logic [31:0] prev_t;
    bit          have_prev;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        pos_gain  = ofme_pkg::POS_GAIN_RST;
        tilt_gain = ofme_pkg::TILT_GAIN_RST;
        offs_gain = ofme_pkg::OFFS_GAIN_RST;
        vel_gain  = ofme_pkg::VEL_GAIN_RST;
        filt_x = 0; filt_y = 0; bias_x = 0; bias_y = 0;
        prev_x = 0; prev_y = 0; vel_x = 0; vel_y = 0;
        prev_t = 0; have_prev = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            ofme_pkg::REG_POS_GAIN:  pos_gain  = val[16:0];
            ofme_pkg::REG_TILT_GAIN: tilt_gain = val[16:0];
            ofme_pkg::REG_OFFS_GAIN: offs_gain = val;
            ofme_pkg::REG_VEL_GAIN:  vel_gain  = val[16:0];
            default: ;
        endcase
    endfunction

    static function logic signed [31:0] clip(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    static function logic signed [31:0] smooth(logic signed [31:0] s,
                                               logic signed [127:0] target,
                                               logic [16:0] gain);
        logic signed [127:0] d;
        d = (target - s) * $signed({1'b0, gain});
        return clip(s + (d >>> 16));
    endfunction

    static function logic signed [63:0] atan_step(int i);
        case (i)
            0: return 294912000;   1: return 174096719;  2: return 91987925;
            3: return 46694507;    4: return 23437865;   5: return 11730359;
            6: return 5866610;     7: return 2933484;    8: return 1466765;
            9: return 733385;      10: return 366693;    11: return 183346;
            12: return 91673;      13: return 45837;     14: return 22918;
            15: return 11459;      16: return 5730;      17: return 2865;
            18: return 1432;       default: return 716;
        endcase
    endfunction

    static function logic signed [63:0] tan_q16(logic signed [14:0] cdeg);
        logic signed [63:0] x, y, z, a, b, ang;
        ang = cdeg;
        if (ang > 8900) ang = 8900;
        if (ang < -8900) ang = -8900;
        x = 64'sd1 <<< 30; y = 0; z = ang * 65536;
        for (int i = 0; i < 20; i++) begin
            a = y >>> i; b = x >>> i;
            if (z >= 0) begin x = x - a; y = y + b; z = z - atan_step(i); end
            else begin x = x + a; y = y - b; z = z + atan_step(i); end
        end
        if (x < 1) x = 1;
        return (y * 65536) / x;
    endfunction

    function logic signed [31:0] tilt_next(logic signed [31:0] bias,
                                           logic signed [14:0] cdeg);
        logic signed [127:0] t;
        t = ($signed({1'b0, offs_gain}) * tan_q16(cdeg)) >>> 16;
        return smooth(bias, t, tilt_gain);
    endfunction

    function logic signed [31:0] vel_next(logic signed [31:0] v, logic signed [31:0] o,
                                          logic signed [31:0] p, logic [31:0] dt);
        logic signed [127:0] r;
        r = ((128'(o) - p) * 1000) / $signed({1'b0, dt});
        return smooth(v, clip(r), vel_gain);
    endfunction

    function void note_sample(logic [127:0] d);
        logic [31:0] t, dt;
        logic signed [31:0] ox, oy, alt;
        logic signed [127:0] cpi;
        t = d[31:0];
        alt = d[125:94];
        filt_x = smooth(filt_x, $signed(d[47:32]) * 65536, pos_gain);
        filt_y = smooth(filt_y, $signed(d[63:48]) * 65536, pos_gain);
        bias_x = tilt_next(bias_x, d[78:64]);
        bias_y = tilt_next(bias_y, d[93:79]);
        ox = clip(128'(filt_x) - bias_x);
        oy = clip(128'(filt_y) - bias_y);
        dt = t - prev_t;
        if (have_prev && dt != 0) begin
            vel_x = vel_next(vel_x, ox, prev_x, dt);
            vel_y = vel_next(vel_y, oy, prev_y, dt);
        end
        prev_t = t; prev_x = ox; prev_y = oy; have_prev = 1;
        cpi = (128'(alt) * 915663668) >>> 32;
        pending.push_back({clip((vel_y * cpi) >>> 16), clip((vel_x * cpi) >>> 16),
                           clip((oy * cpi) >>> 16), clip((ox * cpi) >>> 16)});
    endfunction

    function void check_result(logic [127:0] got);
        logic [127:0] exp_r;
        if (pending.size() == 0) begin
            report_err("result with no sample pending", 0, 0);
            return;
        end
        exp_r = pending.pop_front();
        for (int f = 0; f < 4; f++)
            if (got[32*f +: 32] !== exp_r[32*f +: 32])
                report_err("field mismatch", got[32*f +: 32], exp_r[32*f +: 32]);
    endfunction

    function void report_err(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endfunction
endclass

module tb_optical_flow_motion_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_addr = 0;
    logic [23:0] cfg_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [127:0] m_tdata;

    flow_scoreboard flow_sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int cycles = 0;
    logic [31:0] stamp = 0;

    optical_flow_motion_estimator uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            flow_sb.check_result(m_tdata);

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic write_gain(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        flow_sb.write_reg(idx, val);
    endtask

    task automatic send_sample(logic [31:0] t, logic [15:0] dx, logic [15:0] dy,
                               logic [14:0] roll, logic [14:0] pitch, logic [31:0] alt);
        logic [127:0] d;
        d = {2'd0, alt, pitch, roll, dy, dx, t};
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        s_tvalid <= 1; s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        flow_sb.note_sample(d);
        @(negedge clk);
        s_tvalid <= 0;
    endtask

    task automatic settle();
        while (flow_sb.pending.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    function automatic logic [14:0] rand_angle();
        int a;
        a = $urandom_range(17800) - 8900;
        if ($urandom_range(9) == 0) a = $urandom_range(1) ? 16383 : -16384;
        return 15'(a);
    endfunction

    task automatic random_samples(int n);
        logic [31:0] alt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: stamp = stamp;
                1: stamp = stamp + $urandom;
                default: stamp = stamp + $urandom_range(200, 1);
            endcase
            alt = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(20, 0)) <<< 16;
            if ($urandom_range(1)) alt = -alt;
            send_sample(stamp, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400) - 200),
                        $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400) - 200),
                        rand_angle(), rand_angle(), alt);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: first sample, repeated stamp, wrap, extremes, clamped angles
        send_sample(32'd0, 16'h7fff, 16'h8000, 15'sd8900, -15'sd8900, 32'h7fffffff);
        send_sample(32'd0, 16'h8000, 16'h7fff, 15'h3fff, 15'h4000, 32'h80000000);
        send_sample(32'd20, 16'd5, -16'sd5, 15'd0, 15'd0, 32'h00050000);
        send_sample(32'hfffffff0, 16'hffff, 16'h0001, 15'sd8899, -15'sd8899, 32'hffff0000);
        send_sample(32'h00000010, 16'h0000, 16'h0000, 15'h7fff, 15'h0001, 32'h00000000);
        send_sample(32'h00000011, 16'h5555, 16'haaaa, 15'h2aaa, 15'h5555, 32'h55555555);
        send_sample(32'h00000011, 16'haaaa, 16'h5555, 15'h5555, 15'h2aaa, 32'haaaaaaaa);
        send_sample(32'hffffffff, 16'h0100, 16'hff00, 15'sd100, -15'sd100, 32'h00010000);
        settle();

        write_gain(ofme_pkg::REG_POS_GAIN, 24'd65536);
        write_gain(ofme_pkg::REG_TILT_GAIN, 24'd0);
        write_gain(ofme_pkg::REG_OFFS_GAIN, 24'hffffff);
        write_gain(ofme_pkg::REG_VEL_GAIN, 24'd65536);
        write_gain(3'd7, 24'd1);
        stamp = 1000;
        random_samples(100);
        settle();

        send_idle = 53;
        write_gain(ofme_pkg::REG_POS_GAIN, 24'h1ffff);
        write_gain(ofme_pkg::REG_TILT_GAIN, 24'h1ffff);
        write_gain(ofme_pkg::REG_OFFS_GAIN, 24'd0);
        write_gain(ofme_pkg::REG_VEL_GAIN, 24'h1ffff);
        random_samples(100);
        settle();

        send_idle = 0; recv_stall = 53;
        write_gain(ofme_pkg::REG_POS_GAIN, 24'd0);
        write_gain(ofme_pkg::REG_TILT_GAIN, 24'd65536);
        write_gain(ofme_pkg::REG_OFFS_GAIN, 24'd131072);
        write_gain(ofme_pkg::REG_VEL_GAIN, 24'd0);
        random_samples(100);
        settle();

        send_idle = 9; recv_stall = 9;
        for (int r = 0; r < 4; r++)
            write_gain(3'(r), 24'($urandom_range(70000)));
        random_samples(100);

        while (flow_sb.pending.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
        if (flow_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
hdl/ofme_pkg.sv
hdl/ofme_muldiv.sv
hdl/ofme_cordic.sv
hdl/optical_flow_motion_estimator.sv
dv/tb_optical_flow_motion_estimator.sv
